>>> sv/hsvc_pkg.sv
package hsvc_pkg;

	// channel and result widths
	localparam int CHAN_W = 8;
	localparam int FRAC_W = 16;

	// divider layout: quotient bits retired per stage and stage count
	localparam int BITS_PER_STAGE = 4;
	localparam int DIV_STAGES     = FRAC_W / BITS_PER_STAGE;

	// hue divisor is 6*C, three bits wider than a channel
	localparam int HDIV_W = CHAN_W + 3;
	localparam int HREM_W = CHAN_W + 4;
	localparam int SREM_W = CHAN_W + 1;
	localparam int NUM_W  = CHAN_W + 4;

	// which channel holds the maximum
	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// input pixel
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              last_pixel;
	} pix_in_t;

	// output pixel
	typedef struct packed {
		logic [FRAC_W-1:0] hue;
		logic [FRAC_W-1:0] saturation;
		logic [CHAN_W-1:0] value;
		logic              last_out;
	} pix_out_t;

	// state of both long divisions as it moves down the pipe
	typedef struct packed {
		logic [SREM_W-1:0] sat_rem;
		logic [CHAN_W-1:0] sat_div;
		logic [FRAC_W-1:0] sat_low;
		logic [FRAC_W-1:0] sat_q;
		logic [HREM_W-1:0] hue_rem;
		logic [HDIV_W-1:0] hue_div;
		logic [FRAC_W-1:0] hue_q;
		logic [CHAN_W-1:0] value;
		logic              grey;
		logic              last;
	} div_work_t;

endpackage

>>> sv/hsvc_prep.sv
module hsvc_prep
	import hsvc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_in,
	input  pix_in_t   pix_in,
	output logic      ready_in,
	output logic      valid_out,
	output div_work_t work_out,
	input  logic      ready_out
);

	logic              valid_s1;
	logic [CHAN_W-1:0] red_s1;
	logic [CHAN_W-1:0] green_s1;
	logic [CHAN_W-1:0] blue_s1;
	logic [CHAN_W-1:0] max_s1;
	logic [CHAN_W-1:0] min_s1;
	sector_t           sector_s1;
	logic              last_s1;

	logic              valid_s2;
	div_work_t         work_s2;

	logic              ready_s2;

	logic [CHAN_W-1:0] max_c;
	logic [CHAN_W-1:0] min_c;
	logic [CHAN_W-1:0] rg_max;
	logic [CHAN_W-1:0] rg_min;
	sector_t           sector_c;

	logic [CHAN_W-1:0]          chroma;
	logic [HDIV_W-1:0]          six_c;
	logic signed [NUM_W-1:0]    num_raw;
	logic signed [NUM_W-1:0]    num_fix;
	logic [CHAN_W+FRAC_W-1:0]   sat_dividend;
	div_work_t                  work_c;

	// per-stage flow control
	assign ready_s2 = !valid_s2 || ready_out;
	assign ready_in = !valid_s1 || ready_s2;

	// max, min and sector, ties go red then green then blue
	always_comb begin
		rg_max = (pix_in.red > pix_in.green) ? pix_in.red : pix_in.green;
		rg_min = (pix_in.red < pix_in.green) ? pix_in.red : pix_in.green;
		max_c  = (rg_max > pix_in.blue) ? rg_max : pix_in.blue;
		min_c  = (rg_min < pix_in.blue) ? rg_min : pix_in.blue;
		if (max_c == pix_in.red) begin
			sector_c = SEC_RED;
		end else if (max_c == pix_in.green) begin
			sector_c = SEC_GREEN;
		end else begin
			sector_c = SEC_BLUE;
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_in) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in && ready_in) begin
			red_s1    <= pix_in.red;
			green_s1  <= pix_in.green;
			blue_s1   <= pix_in.blue;
			max_s1    <= max_c;
			min_s1    <= min_c;
			sector_s1 <= sector_c;
			last_s1   <= pix_in.last_pixel;
		end
	end

	// chroma, hue numerator folded into [0, 6C), initial remainders
	always_comb begin
		chroma = max_s1 - min_s1;
		six_c  = {1'b0, chroma, 2'b00} + {2'b00, chroma, 1'b0};
		case (sector_s1)
			SEC_RED: begin
				num_raw = $signed({4'b0000, green_s1}) - $signed({4'b0000, blue_s1});
			end
			SEC_GREEN: begin
				num_raw = $signed({4'b0000, blue_s1}) - $signed({4'b0000, red_s1})
					+ $signed({3'b000, chroma, 1'b0});
			end
			default: begin
				num_raw = $signed({4'b0000, red_s1}) - $signed({4'b0000, green_s1})
					+ $signed({2'b00, chroma, 2'b00});
			end
		endcase
		num_fix = num_raw[NUM_W-1] ? (num_raw + $signed({1'b0, six_c})) : num_raw;

		// C*65535 = C*2^16 - C
		sat_dividend = {chroma, {FRAC_W{1'b0}}} - {{FRAC_W{1'b0}}, chroma};

		work_c.sat_rem = {1'b0, sat_dividend[CHAN_W+FRAC_W-1:FRAC_W]};
		work_c.sat_div = max_s1;
		work_c.sat_low = sat_dividend[FRAC_W-1:0];
		work_c.sat_q   = '0;
		work_c.hue_rem = num_fix[HREM_W-1:0];
		work_c.hue_div = six_c;
		work_c.hue_q   = '0;
		work_c.value   = max_s1;
		work_c.grey    = (chroma == '0);
		work_c.last    = last_s1;
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			work_s2 <= work_c;
		end
	end

	assign valid_out = valid_s2;
	assign work_out  = work_s2;

endmodule

>>> sv/hsvc_div_stage.sv
module hsvc_div_stage
	import hsvc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_in,
	input  div_work_t work_in,
	output logic      ready_in,
	output logic      valid_out,
	output div_work_t work_out,
	input  logic      ready_out
);

	logic      valid_s1;
	div_work_t work_s1;

	div_work_t         work_c;
	logic [SREM_W-1:0] sat_try;
	logic [HREM_W-1:0] hue_try;
	logic              sat_bit;
	logic              hue_bit;

	assign ready_in = !valid_s1 || ready_out;

	// BITS_PER_STAGE restoring division steps for both saturation and hue
	always_comb begin
		work_c  = work_in;
		sat_try = '0;
		hue_try = '0;
		sat_bit = 1'b0;
		hue_bit = 1'b0;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			sat_try = {work_c.sat_rem[SREM_W-2:0], work_c.sat_low[FRAC_W-1]};
			sat_bit = (sat_try >= {1'b0, work_c.sat_div});
			work_c.sat_rem = sat_bit ? (sat_try - {1'b0, work_c.sat_div}) : sat_try;
			work_c.sat_low = {work_c.sat_low[FRAC_W-2:0], 1'b0};
			work_c.sat_q   = {work_c.sat_q[FRAC_W-2:0], sat_bit};

			hue_try = {work_c.hue_rem[HREM_W-2:0], 1'b0};
			hue_bit = (hue_try >= {1'b0, work_c.hue_div});
			work_c.hue_rem = hue_bit ? (hue_try - {1'b0, work_c.hue_div}) : hue_try;
			work_c.hue_q   = {work_c.hue_q[FRAC_W-2:0], hue_bit};
		end
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_in) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in && ready_in) begin
			work_s1 <= work_c;
		end
	end

	assign valid_out = valid_s1;
	assign work_out  = work_s1;

endmodule

>>> sv/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter.
// Input channel pix (pix_valid / pix_stall) carries one RGB pixel of three
// unsigned channels and a last-pixel mark. Output channel hsv
// (hsv_valid / hsv_stall) carries hue as a 16-bit fraction of a turn,
// saturation as floor(C*65535/V), value (largest channel) and the mark.
// A transfer happens at a rising edge with valid high and stall low.
// Throughput is one pixel per clock with no gaps while hsv is not stalled;
// pixels are independent. From input transfer to output transfer a pixel
// passes two stages that find max/min/chroma and the hue numerator, then four
// stages of a shared restoring divider that retire four quotient bits each for
// hue and saturation. The last divider stage is the output register.
// Grey pixels (chroma zero) give hue 0 and saturation 0.
// Reset clears every stage valid bit; no pixel is in flight afterwards.
// Each stage holds while the one after it is full and stalled, so a stall
// on hsv backs up stage by stage to pix_stall; empty stages still fill, so
// bubbles are squeezed out and nothing is dropped or repeated.
module rgb_to_hsv_converter
	import hsvc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pix_valid,
	output logic     pix_stall,
	input  pix_in_t  pix,
	output logic     hsv_valid,
	input  logic     hsv_stall,
	output pix_out_t hsv
);

	logic      valid_w [DIV_STAGES+1];
	logic      ready_w [DIV_STAGES+1];
	div_work_t work_w  [DIV_STAGES+1];
	logic      prep_ready;

	// front end: max, min, chroma, numerator
	hsvc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (pix_valid),
		.pix_in    (pix),
		.ready_in  (prep_ready),
		.valid_out (valid_w[0]),
		.work_out  (work_w[0]),
		.ready_out (ready_w[0])
	);

	assign pix_stall = !prep_ready;

	// divider chain
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		hsvc_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (valid_w[k]),
			.work_in   (work_w[k]),
			.ready_in  (ready_w[k]),
			.valid_out (valid_w[k+1]),
			.work_out  (work_w[k+1]),
			.ready_out (ready_w[k+1])
		);
	end

	assign ready_w[DIV_STAGES] = !hsv_stall;

	// result, grey pixels forced to zero hue and saturation
	assign hsv_valid      = valid_w[DIV_STAGES];
	assign hsv.hue        = work_w[DIV_STAGES].grey ? '0 : work_w[DIV_STAGES].hue_q;
	assign hsv.saturation = work_w[DIV_STAGES].grey ? '0 : work_w[DIV_STAGES].sat_q;
	assign hsv.value      = work_w[DIV_STAGES].value;
	assign hsv.last_out   = work_w[DIV_STAGES].last;

endmodule
